>>> rtl/box_minus_box_slab_splitter_top_macros.svh
// Assertion macros for the top-level RTL file, which checks its own behavior.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef BOX_MINUS_BOX_SLAB_SPLITTER_TOP_MACROS_SVH
`define BOX_MINUS_BOX_SLAB_SPLITTER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BMB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BMB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define BMB_ASSERT_IMPLY(lbl, ante, cons)
`define BMB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/bmb_pkg.sv
`timescale 1ns / 1ps
package bmb_pkg;

  localparam int NUM_AXES   = 3;
  localparam int NUM_PLANES = 6;
  localparam int COORD_W    = 32;
  localparam int TEX_W      = 16;
  // The cut plane lies strictly inside the box, so the ratio stays below 1.0.
  localparam int QUO_BITS   = 15;
  localparam int DEN_W      = COORD_W + 1;
  localparam int REM_W      = COORD_W + 2;
  localparam int CFG_IDX_W  = 3;

  localparam logic [TEX_W-1:0] TEX_ONE = 16'h8000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_AREA_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_MAX_Z = 3'd5;

  // Plane order: left, right, top, bottom, front, back.
  localparam logic [NUM_PLANES-1:0][1:0] PLANE_AXIS =
    {2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0};
  localparam logic [NUM_PLANES-1:0] PLANE_IS_MIN = 6'b101001;

  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_W-1:0] lo;
    logic [NUM_AXES-1:0][COORD_W-1:0] hi;
    logic [NUM_AXES-1:0][TEX_W-1:0]   tlo;
    logic [NUM_AXES-1:0][TEX_W-1:0]   thi;
  } slab_t;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] piece_min_x;
    logic signed [31:0] piece_min_y;
    logic signed [31:0] piece_min_z;
    logic signed [31:0] piece_max_x;
    logic signed [31:0] piece_max_y;
    logic signed [31:0] piece_max_z;
    logic [31:0]        tex_s_pair;
    logic [31:0]        tex_t_pair;
    logic [31:0]        tex_p_pair;
    logic               last_piece;
  } out_t;

  // Transaction state while the texture ratios are being divided out.
  typedef struct packed {
    slab_t                                 cur;
    logic [NUM_PLANES-1:0][REM_W-1:0]      rem;
    logic [NUM_AXES-1:0][DEN_W-1:0]        den;
    logic [NUM_PLANES-1:0][QUO_BITS-1:0]   quo;
  } div_item_t;

  // Transaction state while it is cut against the planes.
  typedef struct packed {
    slab_t                                 cur;
    logic [NUM_PLANES-1:0][QUO_BITS-1:0]   quo;
    logic                                  stop;
    logic [NUM_PLANES-1:0]                 emit;
    slab_t [NUM_PLANES-1:0]                piece;
  } plane_item_t;

  // Handshake between the emitter and the cell chain.
  typedef struct packed {
    logic adv;
    logic busy;
  } emit_ctl_t;

endpackage

>>> rtl/bmb_div_cell.sv
`timescale 1ns / 1ps
module bmb_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  bmb_pkg::div_item_t  in_item,
  output logic                out_vld,
  output bmb_pkg::div_item_t  out_item
);
  import bmb_pkg::*;

  logic      vld_r;
  div_item_t item_r;
  div_item_t item_nxt;

  // One restoring-division step per plane lane.
  always_comb begin
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] dd;
    item_nxt = in_item;
    for (int k = 0; k < NUM_PLANES; k++) begin
      r2 = {in_item.rem[k][REM_W-2:0], 1'b0};
      dd = {1'b0, in_item.den[PLANE_AXIS[k]]};
      if (r2 >= dd) begin
        item_nxt.rem[k] = r2 - dd;
        item_nxt.quo[k] = {in_item.quo[k][QUO_BITS-2:0], 1'b1};
      end else begin
        item_nxt.rem[k] = r2;
        item_nxt.quo[k] = {in_item.quo[k][QUO_BITS-2:0], 1'b0};
      end
    end
  end

  // Cell registers move with the whole chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

>>> rtl/bmb_plane_cell.sv
`timescale 1ns / 1ps
module bmb_plane_cell #(
  parameter int STAGE = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic signed [31:0]    plane_pos,
  input  logic                  clip_empty,
  input  logic                  in_vld,
  input  bmb_pkg::plane_item_t  in_item,
  output logic                  out_vld,
  output bmb_pkg::plane_item_t  out_item
);
  import bmb_pkg::*;

  localparam logic [1:0] AX = PLANE_AXIS[STAGE];
  localparam logic       MN = PLANE_IS_MIN[STAGE];

  logic        vld_r;
  plane_item_t item_r;
  plane_item_t item_nxt;

  // Emit the outer part (all if clip empty), keep the rest.
  always_comb begin
    logic signed [31:0] c_lo;
    logic signed [31:0] c_hi;
    logic               whole_out;
    logic               whole_in;
    logic [TEX_W-1:0]   crd;
    item_nxt  = in_item;
    c_lo      = in_item.cur.lo[AX];
    c_hi      = in_item.cur.hi[AX];
    crd       = {1'b0, in_item.quo[STAGE]};
    whole_out = MN ? (c_hi <= plane_pos) : (c_lo >= plane_pos);
    whole_in  = MN ? (c_lo >= plane_pos) : (c_hi <= plane_pos);
    if (!in_item.stop) begin
      if (clip_empty || whole_out) begin
        item_nxt.piece[STAGE] = in_item.cur;
        item_nxt.emit[STAGE]  = 1'b1;
        item_nxt.stop         = 1'b1;
      end else if (!whole_in) begin
        item_nxt.piece[STAGE] = in_item.cur;
        item_nxt.emit[STAGE]  = 1'b1;
        if (MN) begin
          item_nxt.piece[STAGE].hi[AX]  = plane_pos;
          item_nxt.piece[STAGE].thi[AX] = crd;
          item_nxt.cur.lo[AX]           = plane_pos;
          item_nxt.cur.tlo[AX]          = crd;
        end else begin
          item_nxt.piece[STAGE].lo[AX]  = plane_pos;
          item_nxt.piece[STAGE].tlo[AX] = crd;
          item_nxt.cur.hi[AX]           = plane_pos;
          item_nxt.cur.thi[AX]          = crd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

>>> rtl/bmb_emitter.sv
`timescale 1ns / 1ps
module bmb_emitter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ld_vld,
  input  bmb_pkg::plane_item_t  ld_item,
  output bmb_pkg::emit_ctl_t    ctl,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bmb_pkg::out_t         out_data
);
  import bmb_pkg::*;

  logic [NUM_PLANES-1:0] mask_r;
  logic [NUM_PLANES-1:0] mask_nxt;
  slab_t [NUM_PLANES-1:0] pieces_r;
  logic [2:0]            sel;
  slab_t                 sp;
  logic                  last;
  logic                  adv;

  // Pieces leave lowest plane first; the last set bit marks the final piece.
  always_comb begin
    sel = 3'd0;
    for (int k = NUM_PLANES - 1; k >= 0; k--) begin
      if (mask_r[k]) begin
        sel = 3'(k);
      end
    end
  end

  assign sp        = pieces_r[sel];
  assign last      = $onehot(mask_r);
  assign out_valid = |mask_r;
  assign adv       = (mask_r == '0) || (out_ready && last);
  assign ctl.adv   = adv;
  assign ctl.busy  = out_valid;

  always_comb begin
    mask_nxt = mask_r;
    if (adv) begin
      mask_nxt = ld_vld ? ld_item.emit : '0;
    end else if (out_ready) begin
      mask_nxt = mask_r & (mask_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ld_vld) begin
      pieces_r <= ld_item.piece;
    end
  end

  // Output transaction fields.
  always_comb begin
    out_data.piece_min_x = sp.lo[0];
    out_data.piece_min_y = sp.lo[1];
    out_data.piece_min_z = sp.lo[2];
    out_data.piece_max_x = sp.hi[0];
    out_data.piece_max_y = sp.hi[1];
    out_data.piece_max_z = sp.hi[2];
    out_data.tex_s_pair  = {sp.thi[0], sp.tlo[0]};
    out_data.tex_t_pair  = {sp.thi[1], sp.tlo[1]};
    out_data.tex_p_pair  = {sp.thi[2], sp.tlo[2]};
    out_data.last_piece  = last;
  end

endmodule

>>> rtl/box_minus_box_slab_splitter_top.sv
`timescale 1ns / 1ps
// The first piece of a box is shown once its transaction has passed through one entry
// register, 15 division cells, 6 plane cells and the emitter register.
// A box yields up to 6 pieces; the emitter sends one piece per cycle while out_ready
// is high, and the whole cell chain holds while it drains a box.
// Reset (synchronous, rst_n low) empties the chain and clears the clip box to zero.
module box_minus_box_slab_splitter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bmb_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bmb_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [bmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);
  import bmb_pkg::*;

  logic signed [NUM_AXES-1:0][31:0] area_min_r;
  logic signed [NUM_AXES-1:0][31:0] area_max_r;
  logic [NUM_PLANES-1:0][31:0]      planes;
  logic                             clip_empty;
  emit_ctl_t                        ctl;
  logic                             adv;
  logic                             ent_vld_r;
  div_item_t                        ent_item_r;
  div_item_t                        ent_nxt;
  logic        div_vld  [QUO_BITS+1];
  div_item_t   div_item [QUO_BITS+1];
  logic        pl_vld   [NUM_PLANES+1];
  plane_item_t pl_item  [NUM_PLANES+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_min_r <= '0;
      area_max_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AREA_MIN_X: area_min_r[0] <= cfg_wdata;
        REG_AREA_MIN_Y: area_min_r[1] <= cfg_wdata;
        REG_AREA_MIN_Z: area_min_r[2] <= cfg_wdata;
        REG_AREA_MAX_X: area_max_r[0] <= cfg_wdata;
        REG_AREA_MAX_Y: area_max_r[1] <= cfg_wdata;
        REG_AREA_MAX_Z: area_max_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Plane positions in cut order and the empty clip box test.
  always_comb begin
    clip_empty = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      if ($signed(area_max_r[a]) <= $signed(area_min_r[a])) begin
        clip_empty = 1'b1;
      end
    end
    for (int k = 0; k < NUM_PLANES; k++) begin
      planes[k] = PLANE_IS_MIN[k] ? area_min_r[PLANE_AXIS[k]] : area_max_r[PLANE_AXIS[k]];
    end
  end

  assign adv      = ctl.adv;
  assign in_ready = adv;

  // Entry: box sizes and plane offsets that seed the dividers.
  always_comb begin
    logic [DEN_W-1:0] diff;
    ent_nxt        = '0;
    ent_nxt.cur.lo = {in_data.box_min_z, in_data.box_min_y, in_data.box_min_x};
    ent_nxt.cur.hi = {in_data.box_max_z, in_data.box_max_y, in_data.box_max_x};
    for (int a = 0; a < NUM_AXES; a++) begin
      ent_nxt.cur.tlo[a] = '0;
      ent_nxt.cur.thi[a] = TEX_ONE;
      ent_nxt.den[a] = {ent_nxt.cur.hi[a][31], ent_nxt.cur.hi[a]}
                     - {ent_nxt.cur.lo[a][31], ent_nxt.cur.lo[a]};
    end
    for (int k = 0; k < NUM_PLANES; k++) begin
      diff = {planes[k][31], planes[k]}
           - {ent_nxt.cur.lo[PLANE_AXIS[k]][31], ent_nxt.cur.lo[PLANE_AXIS[k]]};
      ent_nxt.rem[k] = {diff[DEN_W-1], diff};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
    end else if (adv) begin
      ent_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ent_item_r <= ent_nxt;
    end
  end

  // Division cells: one quotient bit per cell.
  assign div_vld[0]  = ent_vld_r;
  assign div_item[0] = ent_item_r;

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
    bmb_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (div_vld[i]),
      .in_item  (div_item[i]),
      .out_vld  (div_vld[i+1]),
      .out_item (div_item[i+1])
    );
  end

  // Plane cells: one cut per cell.
  always_comb begin
    pl_item[0]      = '0;
    pl_item[0].cur  = div_item[QUO_BITS].cur;
    pl_item[0].quo  = div_item[QUO_BITS].quo;
  end
  assign pl_vld[0] = div_vld[QUO_BITS];

  for (genvar s = 0; s < NUM_PLANES; s++) begin : g_plane
    bmb_plane_cell #(.STAGE(s)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .plane_pos  (planes[s]),
      .clip_empty (clip_empty),
      .in_vld     (pl_vld[s]),
      .in_item    (pl_item[s]),
      .out_vld    (pl_vld[s+1]),
      .out_item   (pl_item[s+1])
    );
  end

  bmb_emitter u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_vld    (pl_vld[NUM_PLANES]),
    .ld_item   (pl_item[NUM_PLANES]),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`include "box_minus_box_slab_splitter_top_macros.svh"

  // A stalled piece freezes the chain.
  `BMB_ASSERT_IMPLY(a_stall_holds_chain, out_valid && !out_ready, !adv)
  // More pieces of the same box follow without a gap.
  `BMB_ASSERT_NEXT(a_pieces_back_to_back, out_valid && out_ready && !out_data.last_piece,
                   out_valid)
  // The emitter only takes a new box once its last piece goes.
  `BMB_ASSERT_IMPLY(a_load_after_last, ctl.busy && adv, out_data.last_piece && out_ready)

endmodule
